>>> hw/rtl/ssmq_pkg.sv
// ssmq_pkg: shared types, codes and sizes for the sorted set minimum queue.
// No dependencies; imported by ssmq_cell and sorted_set_min_queue.
package ssmq_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_W     = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 6;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]          t_count;
    typedef logic [CMD_W-1:0]          t_cmd;
    typedef logic [STATUS_W-1:0]       t_status;

    // commands carried in s_axis_tuser
    localparam t_cmd CMD_PUSH = 2'd0;
    localparam t_cmd CMD_POP  = 2'd1;
    localparam t_cmd CMD_PEEK = 2'd2;

    // result status carried in m_axis_tuser
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_DUP   = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

    // what every cell does this cycle
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD   = 2'd0;
    localparam t_cell_op CELL_INSERT = 2'd1;
    localparam t_cell_op CELL_SHIFT  = 2'd2;

    typedef struct packed {
        t_cell_op op;
        t_value   value;
    } t_cell_ctl;

    typedef struct packed {
        t_value value;
        logic   lt;
        logic   eq;
    } t_cell_out;

endpackage

>>> hw/rtl/sorted_set_min_queue.sv
// sorted_set_min_queue: ordered set of signed 32-bit values with min pop/peek.
// Top level; depends on ssmq_pkg and ssmq_cell.
//
// Usage:
//   Input transactions arrive on s_axis_*: tuser carries the command (push,
//   pop, peek), tdata the value to push. Each input transaction gives one
//   result transaction on m_axis_*: tdata holds the smallest value (pop/peek)
//   and the count after the operation, tuser holds the status.
//   The values sit in a row of CAPACITY cells kept in ascending order. A push
//   is compared in every cell at once and the cells above the insert point
//   move up by one; a pop moves every cell down by one. One transaction is
//   taken per cycle while the receiver does not stall, and its result
//   appears in the output register on the following cycle.
//   The result sits in an output register; while the receiver stalls, one
//   result is held and s_axis_tready drops until it is taken.
//   Reset (synchronous, active low) empties the store and drops any pending
//   result. Cell contents are not cleared; slots above the count are unused.
module sorted_set_min_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ssmq_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value_in
    input  ssmq_pkg::t_cmd                  s_axis_tuser,  // [1:0] command
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ssmq_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [31:0] value_out,
                                                           // [37:32] count_after
    output ssmq_pkg::t_status               m_axis_tuser   // [1:0] status
);
    import ssmq_pkg::*;

    t_count    r_count;
    t_count    n_count;
    logic      r_out_valid;
    t_value    r_out_value;
    t_status   r_out_status;
    t_count    r_out_count;
    t_value    n_out_value;
    t_status   n_out_status;

    logic      w_accept;
    t_value    w_value_in;
    logic      w_dup;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;

    t_cell_out w_cell       [CAPACITY];
    logic      w_valid      [CAPACITY];
    logic      w_left_lt    [CAPACITY];
    t_value    w_left_value [CAPACITY];
    t_value    w_right_value[CAPACITY];
    logic [CAPACITY-1:0] w_eq_vec;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_value_in    = t_value'(s_axis_tdata[VALUE_W-1:0]);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_valid[gi]  = (t_count'(gi) < r_count);
            assign w_eq_vec[gi] = w_cell[gi].eq;

            if (gi == 0) begin : g_first
                assign w_left_lt[gi]    = 1'b1;
                assign w_left_value[gi] = '0;
            end else begin : g_inner
                assign w_left_lt[gi]    = w_cell[gi-1].lt;
                assign w_left_value[gi] = w_cell[gi-1].value;
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_right_value[gi] = '0;
            end else begin : g_body
                assign w_right_value[gi] = w_cell[gi+1].value;
            end

            ssmq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_valid       (w_valid[gi]),
                .i_left_lt     (w_left_lt[gi]),
                .i_left_value  (w_left_value[gi]),
                .i_right_value (w_right_value[gi]),
                .o_cell        (w_cell[gi])
            );
        end
    endgenerate

    assign w_dup   = |w_eq_vec;
    assign w_full  = (r_count == t_count'(CAPACITY));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_ctl.value  = w_value_in;
        w_ctl.op     = CELL_HOLD;
        n_count      = r_count;
        n_out_value  = '0;
        n_out_status = ST_OK;
        if (w_accept) begin
            unique case (s_axis_tuser)
                CMD_PUSH: begin
                    // a duplicate wins over full
                    if (w_dup) begin
                        n_out_status = ST_DUP;
                    end else if (w_full) begin
                        n_out_status = ST_FULL;
                    end else begin
                        w_ctl.op = CELL_INSERT;
                        n_count  = r_count + t_count'(1);
                    end
                end
                CMD_POP, CMD_PEEK: begin
                    if (w_empty) begin
                        n_out_value  = t_value'(-1);
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_out_value = w_cell[0].value;
                        if (s_axis_tuser == CMD_POP) begin
                            w_ctl.op = CELL_SHIFT;
                            n_count  = r_count - t_count'(1);
                        end
                    end
                end
                default: begin
                    n_out_value  = '0;
                    n_out_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_count  <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {{(M_TDATA_W - VALUE_W - COUNT_OUT_W){1'b0}},
                            COUNT_OUT_W'(r_out_count), r_out_value};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("occupancy above capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == CMD_PUSH && !w_dup && !w_full)
        |=> (r_count == $past(r_count) + t_count'(1)))
        else $error("accepted push did not grow the store");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == CMD_POP && !w_empty)
        |=> (r_count == $past(r_count) - t_count'(1)))
        else $error("pop did not shrink the store");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> m_axis_tvalid)
        else $error("transaction accepted without a result");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (r_out_count == '0))
        else $error("empty status with nonzero count");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= t_count'(2)) |-> ($signed(w_cell[0].value) < $signed(w_cell[1].value)))
        else $error("head of the store out of order");

endmodule

>>> hw/rtl/ssmq_cell.sv
// ssmq_cell: one slot of the sorted chain; compares against the pushed value
// and takes that value or data from its left or right neighbour. Depends on ssmq_pkg.
module ssmq_cell (
    input  logic                  i_clk,
    input  ssmq_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_valid,
    input  logic                  i_left_lt,
    input  ssmq_pkg::t_value      i_left_value,
    input  ssmq_pkg::t_value      i_right_value,
    output ssmq_pkg::t_cell_out   o_cell
);
    import ssmq_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   w_lt;

    assign w_lt = i_valid && ($signed(r_value) < $signed(i_ctl.value));

    assign o_cell.value = r_value;
    assign o_cell.lt    = w_lt;
    assign o_cell.eq    = i_valid && (r_value == i_ctl.value);

    always_comb begin
        unique case (i_ctl.op)
            CELL_INSERT: begin
                // the prefix below the new value stays; the slot at the
                // boundary takes the value, the rest move up by one
                if (w_lt) begin
                    n_value = r_value;
                end else if (i_left_lt) begin
                    n_value = i_ctl.value;
                end else begin
                    n_value = i_left_value;
                end
            end
            CELL_SHIFT: n_value = i_right_value;
            default:    n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

>>> sim/tb.sv
// tb: self-checking testbench for sorted_set_min_queue (push, pop, peek on a sorted set).
// Depends on ssmq_pkg and the RTL; predicts every result from its own ordered store model
// and drives random gaps and stalls on both streams, with one long output stall.
`timescale 1ns / 100ps

module tb;
    import ssmq_pkg::*;

    localparam int   HALF_PERIOD  = 4;
    localparam int   RESET_CYCLES = 6;
    localparam int   RANDOM_ITEMS = 850;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   LONG_HOLD    = 200;
    localparam t_cmd CMD_NONE     = 2'd3;  // undefined command; the block leaves the store unchanged and answers OK

    typedef struct {
        t_cmd   cmd;
        t_value value;
    } t_set_op;

    typedef struct {
        t_value                 value;
        t_status                status;
        logic [COUNT_OUT_W-1:0] count;
    } t_set_result;

    typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} t_segment;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // [31:0] value_in
    t_cmd                 s_axis_tuser = CMD_PUSH;  // [1:0] command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;  // [31:0] value_out, [37:32] count_after
    t_status              m_axis_tuser;  // [1:0] status

    t_set_op     op_backlog[$];
    t_set_result awaited_results[$];
    t_value      sorted_store[$];

    int mismatches = 0;
    int results_taken = 0;
    int cycles = 0;
    int send_gap = 0;
    int send_steady = 0;
    int hold_left = 0;
    int take_steady = 0;
    bit long_hold_done = 1'b0;

    sorted_set_min_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Applies one command to the ordered store and returns the result it should give.
    function automatic t_set_result apply_to_store(t_cmd cmd, t_value v);
        t_set_result r;
        int          pos;
        r.value  = '0;
        r.status = ST_OK;
        pos      = 0;
        case (cmd)
            CMD_PUSH: begin
                while (pos < sorted_store.size() && sorted_store[pos] < v)
                    pos++;
                if (pos < sorted_store.size() && sorted_store[pos] == v)
                    r.status = ST_DUP;
                else if (sorted_store.size() >= CAPACITY)
                    r.status = ST_FULL;
                else
                    sorted_store.insert(pos, v);
            end
            CMD_POP, CMD_PEEK: begin
                if (sorted_store.size() == 0) begin
                    r.value  = -1;
                    r.status = ST_EMPTY;
                end else begin
                    r.value = sorted_store[0];
                    if (cmd == CMD_POP)
                        void'(sorted_store.pop_front());
                end
            end
            default: ;
        endcase
        r.count = COUNT_OUT_W'(sorted_store.size());
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small pool to provoke duplicates, the range ends, or anything at all.
    function automatic t_value pick_value();
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                k = $urandom_range(0, 40);
                return t_value'(k - 20);
            end
            5: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh8000_0001;
                    default: return 32'sh7fff_fffe;
                endcase
            end
            default: return t_value'($urandom);
        endcase
    endfunction

    function automatic t_cmd pick_cmd(t_segment seg);
        int r;
        r = $urandom_range(0, 99);
        case (seg)
            SEG_FILL:  return r < 80 ? CMD_PUSH : r < 90 ? CMD_POP : r < 98 ? CMD_PEEK : CMD_NONE;
            SEG_DRAIN: return r < 25 ? CMD_PUSH : r < 80 ? CMD_POP : r < 98 ? CMD_PEEK : CMD_NONE;
            default:   return r < 40 ? CMD_PUSH : r < 70 ? CMD_POP : r < 95 ? CMD_PEEK : CMD_NONE;
        endcase
    endfunction

    task automatic add_op(t_cmd cmd, t_value v);
        t_set_op op;
        op.cmd   = cmd;
        op.value = v;
        op_backlog.push_back(op);
    endtask

    // Driver: presents queued commands with random gaps and predicts on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(apply_to_store(s_axis_tuser, t_value'(s_axis_tdata)));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (op_backlog.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= op_backlog[0].cmd;
                    s_axis_tdata  <= op_backlog[0].value;
                    void'(op_backlog.pop_front());
                    if (send_steady > 0) begin
                        send_steady--;
                    end else begin
                        if ($urandom_range(0, 99) == 0)
                            send_steady = $urandom_range(40, 120);
                        send_gap = draw_gap();
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction and draws the receiver's stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_taken++;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none got value %0d status %0d",
                             $time, $signed(m_axis_tdata[31:0]), m_axis_tuser);
                end else begin
                    if (m_axis_tdata[31:0] !== awaited_results[0].value) begin
                        mismatches++;
                        $display("%0t: value_out expected %0d got %0d", $time,
                                 awaited_results[0].value, $signed(m_axis_tdata[31:0]));
                    end
                    if (m_axis_tuser !== awaited_results[0].status) begin
                        mismatches++;
                        $display("%0t: status expected %0d got %0d", $time,
                                 awaited_results[0].status, m_axis_tuser);
                    end
                    if (m_axis_tdata[37:32] !== awaited_results[0].count) begin
                        mismatches++;
                        $display("%0t: count_after expected %0d got %0d", $time,
                                 awaited_results[0].count, m_axis_tdata[37:32]);
                    end
                    if (m_axis_tdata[M_TDATA_W-1:38] !== '0) begin
                        mismatches++;
                        $display("%0t: tdata padding expected 0 got %b", $time,
                                 m_axis_tdata[M_TDATA_W-1:38]);
                    end
                    void'(awaited_results.pop_front());
                end
                // one long stall so the result register and the input both back up
                if (!long_hold_done && results_taken == 300) begin
                    long_hold_done = 1'b1;
                    hold_left      = LONG_HOLD;
                    take_steady    = 0;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (take_steady > 0) begin
                take_steady--;
                m_axis_tready <= 1'b1;
            end else begin
                if ($urandom_range(0, 99) == 0)
                    take_steady = $urandom_range(40, 120);
                hold_left = draw_gap();
                m_axis_tready <= (hold_left == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int       counted;
        int       seg_len;
        t_segment seg;
        t_cmd     cmd;

        // empty store, undefined command, append onto a single value, duplicates, range ends
        add_op(CMD_POP,  32'sd9);
        add_op(CMD_PEEK, -32'sd1);
        add_op(CMD_NONE, -32'sd1);
        add_op(CMD_PUSH, 32'sd5);
        add_op(CMD_PUSH, 32'sd7);
        add_op(CMD_PUSH, 32'sd5);
        add_op(CMD_PUSH, 32'sh8000_0000);
        add_op(CMD_PUSH, 32'sh7fff_ffff);
        add_op(CMD_PUSH, -32'sd1);
        add_op(CMD_PUSH, 32'sd0);
        add_op(CMD_PUSH, 32'sh8000_0000);
        add_op(CMD_PEEK, 32'sd0);
        add_op(CMD_NONE, 32'sd3);
        add_op(CMD_POP,  32'sh7fff_ffff);
        add_op(CMD_POP,  32'sd0);
        add_op(CMD_PUSH, 32'sh7fff_ffff);
        add_op(CMD_POP,  32'sd0);
        add_op(CMD_POP,  32'sd0);
        add_op(CMD_POP,  32'sd0);
        add_op(CMD_POP,  32'sd0);
        add_op(CMD_POP,  32'sd0);
        add_op(CMD_PEEK, 32'sd0);

        // alternate runs that fill, drain or mix so full and empty are both visited often
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            seg     = t_segment'($urandom_range(0, 2));
            seg_len = $urandom_range(20, 80);
            repeat (seg_len) begin
                cmd = pick_cmd(seg);
                add_op(cmd, pick_value());
                if (cmd != CMD_NONE)
                    counted++;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
